// ===== rtl/core/wav_hp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser package
// Types and constants shared by the parser and its checker.
// ----------------------------------------------------------------------------
package wav_hp_pkg;

    localparam int OUT_DATA_W = 120;   // 119 payload bits, padded to bytes

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [15:0] FMT_PCM     = 16'd1;
    localparam logic [31:0] FMT_MIN_LEN = 32'd16;
    localparam logic [15:0] BITS_8      = 16'd8;
    localparam logic [15:0] BITS_16     = 16'd16;
    localparam logic [15:0] MAX_CHAN    = 16'd2;

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_HDR,
        PH_FMT,
        PH_SKIP,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOTWAV  = 3'd1,
        ST_BADHDR  = 3'd2,
        ST_UNSUPP  = 3'd3,
        ST_MISSING = 3'd4
    } status_t;

endpackage

// ===== rtl/core/wav_header_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser
// Walks a RIFF/WAVE byte stream, captures the PCM fmt fields and the data
// chunk location, and reports one status beat per file.
//
//   channel | dir | tdata                  | tuser  | tlast
//   s_      | in  | file byte              | -      | last byte of file
//   m_      | out | fmt fields, data chunk | status | -
//
// One byte per cycle sustained while no result beat is stalled. Input register,
// one combinational update of the parse state, result register: the byte that
// decides a result beat passes the input register before the beat is registered.
// aresetn clears the parse state and the valid flags of both beat registers.
// A stalled result beat holds the byte behind it in the input register; the
// next byte is taken once that result is taken.
// ----------------------------------------------------------------------------
module wav_header_parser (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] data_byte
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [1:0] channels, [33:2] rate_hz, [49:34] block_align,
    // [54:50] bits_per_sample, [86:55] data_offset, [118:87] data_size, [119] 0
    output logic [wav_hp_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [2:0]                        m_tuser    // [2:0] status
);
    import wav_hp_pkg::*;

    logic                  in_vld_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_last_reg;
    logic                  m_vld_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    status_t               m_status_reg;
    logic                  advance;
    logic                  step;

    phase_t      phase_reg,     phase_next;
    logic [31:0] pos_reg,       pos_next;
    logic [3:0]  cnt_reg,       cnt_next;
    logic [31:0] word_reg,      word_next;
    logic [31:0] tag_reg,       tag_next;
    logic [31:0] len_reg,       len_next;
    logic [32:0] skip_reg,      skip_next;
    logic [15:0] fmt_tag_reg,   fmt_tag_next;
    logic [15:0] chan_reg,      chan_next;
    logic [31:0] rate_reg,      rate_next;
    logic [15:0] align_reg,     align_next;
    logic [15:0] bits_reg,      bits_next;
    logic [31:0] offset_reg,    offset_next;
    logic [31:0] size_reg,      size_next;
    logic        seen_fmt_reg,  seen_fmt_next;
    logic        seen_data_reg, seen_data_next;

    logic [31:0] word_new;
    logic [31:0] pos_new;
    logic [32:0] hdr_pad;
    logic [32:0] fmt_pad;
    logic        decide;
    status_t     dec_status;
    logic        produce;
    status_t     res_status;
    logic [OUT_DATA_W-1:0] res_data;

    assign advance  = !m_vld_reg || m_tready;
    assign step     = in_vld_reg && advance;
    assign s_tready = !in_vld_reg || advance;

    assign word_new = {in_byte_reg, word_reg[31:8]};
    assign pos_new  = pos_reg + 32'd1;
    assign hdr_pad  = {1'b0, word_new} + {32'd0, word_new[0]};
    assign fmt_pad  = {1'b0, len_reg} + {32'd0, len_reg[0]} - {1'b0, FMT_MIN_LEN};

    // next parse state
    always_comb begin
        phase_next     = phase_reg;
        pos_next       = pos_new;
        cnt_next       = cnt_reg + 4'd1;
        word_next      = word_new;
        tag_next       = tag_reg;
        len_next       = len_reg;
        skip_next      = skip_reg;
        fmt_tag_next   = fmt_tag_reg;
        chan_next      = chan_reg;
        rate_next      = rate_reg;
        align_next     = align_reg;
        bits_next      = bits_reg;
        offset_next    = offset_reg;
        size_next      = size_reg;
        seen_fmt_next  = seen_fmt_reg;
        seen_data_next = seen_data_reg;
        decide         = 1'b0;
        dec_status     = ST_OK;
        case (phase_reg)
            PH_MAGIC: begin
                if (cnt_reg == 4'd3) tag_next = word_new;
                if (cnt_reg == 4'd11) begin
                    cnt_next = '0;
                    if (tag_reg != TAG_RIFF || word_new != TAG_WAVE) begin
                        decide     = 1'b1;
                        dec_status = ST_NOTWAV;
                    end else begin
                        phase_next = PH_HDR;
                    end
                end
            end
            PH_HDR: begin
                if (cnt_reg == 4'd3) tag_next = word_new;
                if (cnt_reg == 4'd7) begin
                    len_next = word_new;
                    cnt_next = '0;
                    if (tag_reg == TAG_FMT) begin
                        if (word_new < FMT_MIN_LEN) begin
                            decide     = 1'b1;
                            dec_status = ST_BADHDR;
                        end else begin
                            phase_next = PH_FMT;
                        end
                    end else begin
                        if (tag_reg == TAG_DATA) begin
                            offset_next    = pos_new;
                            size_next      = word_new;
                            seen_data_next = 1'b1;
                            if (seen_fmt_reg) begin
                                decide     = 1'b1;
                                dec_status = ST_OK;
                            end
                        end
                        skip_next  = hdr_pad;
                        phase_next = (hdr_pad == '0) ? PH_HDR : PH_SKIP;
                    end
                end
            end
            PH_FMT: begin
                if (cnt_reg == 4'd1)  fmt_tag_next = word_new[31:16];
                if (cnt_reg == 4'd3)  chan_next    = word_new[31:16];
                if (cnt_reg == 4'd7)  rate_next    = word_new;
                if (cnt_reg == 4'd13) align_next   = word_new[31:16];
                if (cnt_reg == 4'd15) begin
                    bits_next = word_new[31:16];
                    cnt_next  = '0;
                    if (fmt_tag_reg != FMT_PCM
                            || (word_new[31:16] != BITS_8 && word_new[31:16] != BITS_16)
                            || chan_reg == '0 || chan_reg > MAX_CHAN
                            || rate_reg == '0) begin
                        decide     = 1'b1;
                        dec_status = ST_UNSUPP;
                    end else begin
                        seen_fmt_next = 1'b1;
                        if (seen_data_reg) begin
                            decide     = 1'b1;
                            dec_status = ST_OK;
                        end else begin
                            skip_next  = fmt_pad;
                            phase_next = (fmt_pad == '0) ? PH_HDR : PH_SKIP;
                        end
                    end
                end
            end
            PH_SKIP: begin
                skip_next = skip_reg - 33'd1;
                cnt_next  = '0;
                if (skip_reg == 33'd1) phase_next = PH_HDR;
            end
            default: begin
                pos_next  = pos_reg;
                cnt_next  = cnt_reg;
                word_next = word_reg;
            end
        endcase
        if (decide) phase_next = PH_DONE;
    end

    // result beat
    always_comb begin
        produce    = (phase_reg != PH_DONE) && (decide || in_last_reg);
        res_status = dec_status;
        if (!decide) begin
            case (phase_next)
                PH_MAGIC: res_status = ST_NOTWAV;
                PH_FMT:   res_status = ST_BADHDR;
                default:  res_status = ST_MISSING;
            endcase
        end
        res_data = '0;
        if (res_status == ST_OK) begin
            res_data = {1'b0, size_next, offset_next, bits_next[4:0], align_next,
                        rate_next, chan_next[1:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && in_last_reg)) begin
            phase_reg     <= PH_MAGIC;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            word_reg      <= '0;
            tag_reg       <= '0;
            len_reg       <= '0;
            skip_reg      <= '0;
            fmt_tag_reg   <= '0;
            chan_reg      <= '0;
            rate_reg      <= '0;
            align_reg     <= '0;
            bits_reg      <= '0;
            offset_reg    <= '0;
            size_reg      <= '0;
            seen_fmt_reg  <= 1'b0;
            seen_data_reg <= 1'b0;
        end else if (step) begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            word_reg      <= word_next;
            tag_reg       <= tag_next;
            len_reg       <= len_next;
            skip_reg      <= skip_next;
            fmt_tag_reg   <= fmt_tag_next;
            chan_reg      <= chan_next;
            rate_reg      <= rate_next;
            align_reg     <= align_next;
            bits_reg      <= bits_next;
            offset_reg    <= offset_next;
            size_reg      <= size_next;
            seen_fmt_reg  <= seen_fmt_next;
            seen_data_reg <= seen_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (step && produce) begin
            m_vld_reg <= 1'b1;
        end else if (m_tready) begin
            m_vld_reg <= 1'b0;
        end
        if (step && produce) begin
            m_data_reg   <= res_data;
            m_status_reg <= res_status;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

endmodule

// ===== rtl/core/wav_hp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser port checker
// Watches the result channel for handshake and payload consistency.
// ----------------------------------------------------------------------------
module wav_hp_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [wav_hp_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [2:0]                        m_tuser
);
    import wav_hp_pkg::*;

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
        else $error("error beat carries fmt fields");

    a_ok_fmt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_OK |->
            (m_tdata[1:0] == 2'd1 || m_tdata[1:0] == 2'd2)
            && (m_tdata[54:50] == 5'd8 || m_tdata[54:50] == 5'd16)
            && m_tdata[33:2] != '0)
        else $error("ok beat with unsupported format");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == ST_OK || m_tuser == ST_NOTWAV || m_tuser == ST_BADHDR
            || m_tuser == ST_UNSUPP || m_tuser == ST_MISSING)
        else $error("status out of range");

endmodule

bind wav_header_parser wav_hp_checker u_wav_hp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/sv/wav_verdict_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser scoreboard
// Mirrors the byte-serial RIFF/WAVE walk and holds the report each file is
// due to produce; result beats are compared field by field in order.
// ----------------------------------------------------------------------------
package wav_verdict_tb_pkg;

    import wav_hp_pkg::*;

    localparam logic [31:0] TAG_JUNK = 32'h4B4E_554A;
    localparam logic [31:0] TAG_LIST = 32'h5453_494C;
    localparam int unsigned REPORT_LIMIT = 10;

    typedef struct packed {
        status_t     status;
        logic [1:0]  channels;
        logic [31:0] rate;
        logic [15:0] align;
        logic [4:0]  sample_bits;
        logic [31:0] offset;
        logic [31:0] length;
    } wav_verdict_t;

    class wav_verdict_scoreboard;

        phase_t      phase;
        logic [31:0] pos;
        logic [4:0]  fcnt;
        logic [31:0] sw;
        logic [31:0] tag;
        logic [31:0] clen;
        logic [32:0] skip;
        logic [15:0] ftag;
        logic [15:0] chans;
        logic [31:0] rate;
        logic [15:0] align;
        logic [15:0] sbits;
        logic [31:0] off;
        logic [31:0] dsize;
        bit          seen_fmt;
        bit          seen_data;
        bit          decided;

        wav_verdict_t pending_verdicts[$];
        int unsigned  errors;
        int unsigned  live_bytes;

        function new();
            errors = 0;
            live_bytes = 0;
            rearm();
        endfunction

        function void rearm();
            phase = PH_MAGIC;
            pos = '0;
            fcnt = '0;
            sw = '0;
            tag = '0;
            clen = '0;
            skip = '0;
            ftag = '0;
            chans = '0;
            rate = '0;
            align = '0;
            sbits = '0;
            off = '0;
            dsize = '0;
            seen_fmt = 1'b0;
            seen_data = 1'b0;
            decided = 1'b0;
        endfunction

        function int unsigned pending();
            return pending_verdicts.size();
        endfunction

        function void start_skip(logic [32:0] count);
            skip = count;
            fcnt = '0;
            phase = (count == 33'd0) ? PH_HDR : PH_SKIP;
        endfunction

        // one byte of the walk; returns 1 when a decision is made
        function bit parse_byte(logic [7:0] b, output status_t st);
            logic [4:0] n;
            n = fcnt;
            st = ST_OK;
            pos = pos + 32'd1;
            sw = {b, sw[31:8]};
            case (phase)
                PH_MAGIC: begin
                    if (n == 5'd3) tag = sw;
                    if (n == 5'd11) begin
                        if (tag != TAG_RIFF || sw != TAG_WAVE) begin
                            st = ST_NOTWAV;
                            return 1'b1;
                        end
                        fcnt = '0;
                        phase = PH_HDR;
                        return 1'b0;
                    end
                    fcnt = n + 5'd1;
                    return 1'b0;
                end
                PH_HDR: begin
                    if (n == 5'd3) tag = sw;
                    if (n == 5'd7) begin
                        clen = sw;
                        fcnt = '0;
                        if (tag == TAG_FMT) begin
                            if (clen < FMT_MIN_LEN) begin
                                st = ST_BADHDR;
                                return 1'b1;
                            end
                            phase = PH_FMT;
                            return 1'b0;
                        end
                        if (tag == TAG_DATA) begin
                            off = pos;
                            dsize = clen;
                            seen_data = 1'b1;
                            if (seen_fmt) begin
                                st = ST_OK;
                                return 1'b1;
                            end
                        end
                        start_skip({1'b0, clen} + {32'd0, clen[0]});
                        return 1'b0;
                    end
                    fcnt = n + 5'd1;
                    return 1'b0;
                end
                PH_FMT: begin
                    if (n == 5'd1) ftag = sw[31:16];
                    if (n == 5'd3) chans = sw[31:16];
                    if (n == 5'd7) rate = sw;
                    if (n == 5'd13) align = sw[31:16];
                    if (n == 5'd15) begin
                        sbits = sw[31:16];
                        if (ftag != FMT_PCM || (sbits != BITS_8 && sbits != BITS_16) ||
                            chans == 16'd0 || chans > MAX_CHAN || rate == 32'd0) begin
                            st = ST_UNSUPP;
                            return 1'b1;
                        end
                        seen_fmt = 1'b1;
                        if (seen_data) begin
                            st = ST_OK;
                            return 1'b1;
                        end
                        start_skip({1'b0, clen} + {32'd0, clen[0]} - 33'd16);
                        return 1'b0;
                    end
                    fcnt = n + 5'd1;
                    return 1'b0;
                end
                PH_SKIP: begin
                    if (skip != 33'd0) skip = skip - 33'd1;
                    if (skip == 33'd0) begin
                        fcnt = '0;
                        phase = PH_HDR;
                    end
                    return 1'b0;
                end
                default: return 1'b0;
            endcase
        endfunction

        function void post_verdict(status_t st);
            wav_verdict_t v;
            v = '0;
            v.status = st;
            if (st == ST_OK) begin
                v.channels = chans[1:0];
                v.rate = rate;
                v.align = align;
                v.sample_bits = sbits[4:0];
                v.offset = off;
                v.length = dsize;
            end
            pending_verdicts.push_back(v);
        endfunction

        // accepted input beat
        function void take_byte(logic [7:0] b, logic tail);
            status_t st;
            if (decided) begin
                if (tail) rearm();
                return;
            end
            live_bytes++;
            if (parse_byte(b, st)) begin
                decided = 1'b1;
                phase = PH_DONE;
                post_verdict(st);
            end else if (tail) begin
                if (phase == PH_MAGIC) st = ST_NOTWAV;
                else if (phase == PH_FMT) st = ST_BADHDR;
                else st = ST_MISSING;
                post_verdict(st);
            end
            if (tail) rearm();
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%s mismatch: expected %0h, got %0h", name, want, got);
            end
        endfunction

        // accepted result beat
        function void check_verdict(logic [OUT_DATA_W-1:0] d, logic [2:0] u);
            wav_verdict_t e;
            if (pending_verdicts.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("result beat with no report outstanding: status %0h", u);
                return;
            end
            e = pending_verdicts.pop_front();
            compare_field("status", 32'(e.status), 32'(u));
            compare_field("channels", 32'(e.channels), 32'(d[1:0]));
            compare_field("rate_hz", e.rate, d[33:2]);
            compare_field("block_align", 32'(e.align), 32'(d[49:34]));
            compare_field("bits_per_sample", 32'(e.sample_bits), 32'(d[54:50]));
            compare_field("data_offset", e.offset, d[86:55]);
            compare_field("data_size", e.length, d[118:87]);
            compare_field("pad", 32'd0, 32'(d[119]));
        endfunction

    endclass

endpackage

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser testbench
// Streams directed and randomly built WAV files into the parser byte by byte
// with random gaps and back-pressure, and checks every status beat against
// the scoreboard's running model.
// ----------------------------------------------------------------------------
module testbench;

    import wav_hp_pkg::*;
    import wav_verdict_tb_pkg::*;

    localparam int unsigned RANDOM_BYTES = 650;
    localparam int unsigned STALL_LIMIT  = 2000;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = 8'h00;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [2:0]            m_tuser;

    logic        calm = 1'b0;
    int unsigned stall_cycles = 0;
    logic [7:0]  wav_file[$];

    wav_verdict_scoreboard sb;
    wav_verdict_scoreboard gauge;

    wav_header_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.take_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) sb.check_verdict(m_tdata, m_tuser);
        end
    end

    always @(posedge aclk) m_tready <= calm || ($urandom_range(0, 99) >= 31);

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic void put_word(logic [31:0] w);
        for (int i = 0; i < 4; i++) wav_file.push_back(w[8*i +: 8]);
    endfunction

    function automatic void put_half(logic [15:0] h);
        wav_file.push_back(h[7:0]);
        wav_file.push_back(h[15:8]);
    endfunction

    function automatic void put_junk(int n);
        repeat (n) wav_file.push_back(8'($urandom));
    endfunction

    function automatic void trim_file(int n);
        while (wav_file.size() > n) void'(wav_file.pop_back());
    endfunction

    function automatic void put_preamble();
        put_word(TAG_RIFF);
        put_word($urandom);
        put_word(TAG_WAVE);
    endfunction

    function automatic void put_chunk(logic [31:0] tag, logic [31:0] len, int body);
        put_word(tag);
        put_word(len);
        put_junk(body);
    endfunction

    function automatic void put_fmt(logic [31:0] len, logic [15:0] ftag, logic [15:0] ch,
                                    logic [31:0] rate, logic [15:0] align,
                                    logic [15:0] sbits, int extra);
        put_word(TAG_FMT);
        put_word(len);
        put_half(ftag);
        put_half(ch);
        put_word(rate);
        put_word($urandom);
        put_half(align);
        put_half(sbits);
        put_junk(extra);
    endfunction

    function automatic void put_stray_chunk();
        logic [31:0] tag;
        logic [31:0] len;
        case ($urandom_range(0, 3))
            0: tag = TAG_JUNK;
            1: tag = TAG_LIST;
            2: tag = TAG_FMT ^ (32'd1 << $urandom_range(0, 31));
            default: tag = $urandom;
        endcase
        if ($urandom_range(0, 32) == 0) begin
            put_chunk(tag, $urandom, $urandom_range(0, 5));
        end else begin
            len = $urandom_range(0, 9);
            put_chunk(tag, len, len + len[0]);
        end
    endfunction

    function automatic logic [15:0] pick_format();
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 3));
            default: return FMT_PCM;
        endcase
    endfunction

    function automatic logic [15:0] pick_channels();
        case ($urandom_range(0, 19))
            0: return 16'd0;
            1: return 16'd3;
            2: return 16'($urandom);
            default: return 16'($urandom_range(1, 2));
        endcase
    endfunction

    function automatic logic [31:0] pick_rate();
        case ($urandom_range(0, 19))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_bits();
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(0, 32));
            1: return 16'($urandom);
            default: return $urandom_range(0, 1) ? BITS_8 : BITS_16;
        endcase
    endfunction

    // mostly well-formed files with random content; some noise and damage
    function automatic void build_random_file();
        int          k;
        int          extra;
        logic [31:0] len;
        logic [31:0] flen;
        k = $urandom_range(0, 99);
        if (k < 6) begin
            put_junk($urandom_range(1, 24));
            return;
        end
        put_preamble();
        if (k < 12) wav_file[$urandom_range(0, 11)] ^= 8'(1 << $urandom_range(0, 7));
        repeat ($urandom_range(0, 2)) put_stray_chunk();
        if ($urandom_range(0, 4) == 0) begin
            len = $urandom_range(0, 7);
            put_chunk(TAG_DATA, len, len + len[0]);
        end
        if ($urandom_range(0, 7) == 0)
            put_fmt(32'd16, FMT_PCM, 16'd1, 32'd22050, 16'd1, BITS_8, 0);
        case ($urandom_range(0, 9))
            0, 1: begin
                flen = $urandom_range(17, 23);
                extra = flen - 16 + flen[0];
            end
            2: begin
                flen = $urandom_range(0, 15);
                extra = 0;
            end
            3: begin
                flen = $urandom;
                extra = $urandom_range(0, 4);
            end
            default: begin
                flen = 32'd16;
                extra = 0;
            end
        endcase
        put_fmt(flen, pick_format(), pick_channels(), pick_rate(), 16'($urandom),
                pick_bits(), extra);
        if ($urandom_range(0, 5) == 0) put_stray_chunk();
        if ($urandom_range(0, 9) != 0) put_chunk(TAG_DATA, $urandom, $urandom_range(0, 6));
        if ($urandom_range(0, 6) == 0) trim_file($urandom_range(1, wav_file.size()));
    endfunction

    task automatic send_byte(logic [7:0] b, logic tail);
        if (!calm && $urandom_range(0, 99) < 31) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 31);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= tail;
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    task automatic send_file();
        int n;
        n = wav_file.size();
        for (int i = 0; i < n; i++) gauge.take_byte(wav_file[i], i == n - 1);
        gauge.pending_verdicts.delete();
        for (int i = 0; i < n; i++) send_byte(wav_file[i], i == n - 1);
        wav_file.delete();
    endtask

    // hold the source until every outstanding report has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
        @(posedge aclk);
    endtask

    task automatic run_directed();
        // minimal mono 8-bit file, then hold off
        put_preamble();
        put_fmt(32'd16, FMT_PCM, 16'd1, 32'd8000, 16'd1, BITS_8, 0);
        put_chunk(TAG_DATA, 32'd0, 4);
        send_file();
        drain();
        // widest fields; odd and empty chunks ahead of fmt
        put_preamble();
        put_chunk(TAG_LIST, 32'd3, 4);
        put_chunk(TAG_JUNK, 32'd0, 0);
        put_fmt(32'd16, FMT_PCM, 16'd2, 32'hFFFF_FFFF, 16'hFFFF, BITS_16, 0);
        put_chunk(TAG_DATA, 32'hFFFF_FFFF, 3);
        send_file();
        // bad magic words
        put_word(TAG_RIFF ^ 32'h1E00_0000);
        put_word($urandom);
        put_word(TAG_WAVE);
        put_junk(6);
        send_file();
        put_word(TAG_RIFF);
        put_word(32'd0);
        put_word(TAG_WAVE ^ 32'h0000_0001);
        put_junk(2);
        send_file();
        // cut in the preamble, lone byte, bare preamble
        put_preamble();
        trim_file(5);
        send_file();
        wav_file.push_back(8'hFF);
        send_file();
        put_preamble();
        send_file();
        // cut inside fmt fields, cut inside a chunk header
        put_preamble();
        put_word(TAG_FMT);
        put_word(32'd16);
        put_junk(6);
        send_file();
        put_preamble();
        put_junk(5);
        send_file();
        // fmt too short
        put_preamble();
        put_fmt(32'd15, FMT_PCM, 16'd1, 32'd8000, 16'd1, BITS_8, 0);
        send_file();
        put_preamble();
        put_fmt(32'd0, FMT_PCM, 16'd1, 32'd8000, 16'd1, BITS_8, 2);
        send_file();
        // unsupported formats
        put_preamble();
        put_fmt(32'd16, 16'd3, 16'd1, 32'd8000, 16'd4, BITS_16, 0);
        put_chunk(TAG_DATA, 32'd8, 0);
        send_file();
        put_preamble();
        put_fmt(32'd16, FMT_PCM, 16'd0, 32'd8000, 16'd1, BITS_8, 0);
        put_chunk(TAG_DATA, 32'd8, 0);
        send_file();
        put_preamble();
        put_fmt(32'd16, FMT_PCM, 16'd3, 32'd8000, 16'd3, BITS_8, 0);
        put_chunk(TAG_DATA, 32'd8, 0);
        send_file();
        put_preamble();
        put_fmt(32'd16, FMT_PCM, 16'd2, 32'd8000, 16'd6, 16'd24, 0);
        put_chunk(TAG_DATA, 32'd8, 0);
        send_file();
        put_preamble();
        put_fmt(32'd16, FMT_PCM, 16'd1, 32'd0, 16'd1, BITS_8, 0);
        put_chunk(TAG_DATA, 32'd8, 0);
        send_file();
        // data ahead of fmt, twice; the later one is reported
        put_preamble();
        put_chunk(TAG_DATA, 32'd3, 4);
        put_chunk(TAG_DATA, 32'd2, 2);
        put_fmt(32'd18, FMT_PCM, 16'd2, 32'd44100, 16'd4, BITS_16, 2);
        put_junk(3);
        send_file();
        // repeated fmt, odd length with pad
        put_preamble();
        put_fmt(32'd16, FMT_PCM, 16'd1, 32'd11025, 16'd1, BITS_8, 0);
        put_fmt(32'd17, FMT_PCM, 16'd2, 32'd48000, 16'd4, BITS_16, 2);
        put_chunk(TAG_DATA, 32'd100, 5);
        send_file();
        // fmt completes on the last byte, no data
        put_preamble();
        put_fmt(32'd16, FMT_PCM, 16'd2, 32'd16000, 16'd2, BITS_8, 0);
        send_file();
        // huge skips cut short by the end of file
        put_preamble();
        put_chunk(TAG_JUNK, 32'hFFFF_FFFF, 10);
        send_file();
        put_preamble();
        put_fmt(32'hFFFF_FFFE, FMT_PCM, 16'd1, 32'd8000, 16'd2, BITS_16, 5);
        send_file();
        // decision and end of file on the same byte
        put_preamble();
        put_fmt(32'd16, FMT_PCM, 16'd1, 32'd8000, 16'd1, 16'd12, 0);
        send_file();
    endtask

    initial begin
        int files;
        sb = new();
        gauge = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        gauge.live_bytes = 0;
        files = 0;
        while (gauge.live_bytes < RANDOM_BYTES) begin
            calm <= (files >= 12 && files < 24);
            build_random_file();
            send_file();
            if ($urandom_range(0, 9) == 0) drain();
            files++;
        end
        drain();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
